FILE: rtl/meter_reply_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the meter reply frame parser
// Clocked implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef METER_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH
`define METER_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MRFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrfp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MRFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrfp assertion failed");
`else
`define MRFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// Meter reply frame parser package
// Frame constants, status codes, register indexes and the captured frame
// record passed from the capture stage to the decode stage.
// ----------------------------------------------------------------------------
package mrfp_pkg;

    // Frame marker bytes and byte scrambling constants.
    localparam logic [7:0] START_MARK    = 8'h68;
    localparam logic [7:0] END_MARK      = 8'h16;
    localparam logic [7:0] CONTROL_REPLY = 8'h91;
    localparam logic [7:0] BYTE_OFFSET   = 8'h33;
    localparam logic [7:0] SIGN_MASK     = 8'h7f;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT = 2'd2;
    localparam logic [31:0] ENERGY_ID_RST  = 32'h0000_0000;
    localparam logic [31:0] VOLTAGE_ID_RST = 32'h0201_0100;
    localparam logic [31:0] CURRENT_ID_RST = 32'h0202_0100;

    // Largest value the decoder can produce.
    localparam logic [26:0] READING_MAX = 27'd86666665;

    // Result status codes; the first three also serve as header fault codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DELIM  = 3'd1,
        ST_WRONG_CTRL = 3'd2,
        ST_UNKNOWN_ID = 3'd3,
        ST_TOO_SHORT  = 3'd4
    } t_status;

    // Everything the decoder needs about one finished frame.
    typedef struct packed {
        logic [7:0]  pos;       // offset of the final byte, saturated
        logic        end_ok;    // final byte was the end mark
        t_status     herr;      // first header fault
        logic [47:0] addr;
        logic [31:0] ident;     // identifier with the offset removed
        logic [31:0] data;      // raw data bytes at offsets 18 to 21
    } t_frame;

    // One byte read as a pair of decimal digits.
    function automatic logic [7:0] bcd_pair(input logic [7:0] d);
        logic [7:0] hi;
        logic [7:0] lo;
        begin
            hi = {4'd0, d[7:4]};
            lo = {4'd0, d[3:0]};
            bcd_pair = (hi << 3) + (hi << 1) + lo;
        end
    endfunction

endpackage

FILE: rtl/mrfp_capture.sv
// ----------------------------------------------------------------------------
// Meter reply frame parser capture stage
// Tracks the byte offset, checks header bytes and captures the address,
// identifier and data bytes. The final byte loads a frame record register.
// ----------------------------------------------------------------------------
module mrfp_capture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_last_byte,
    output logic             o_frm_valid,
    input  logic             i_frm_ready,
    output mrfp_pkg::t_frame o_frm
);
    import mrfp_pkg::*;

    localparam logic [7:0] POS_START1 = 8'd4;
    localparam logic [7:0] POS_ADDR0  = 8'd5;
    localparam logic [7:0] POS_ADDR5  = 8'd10;
    localparam logic [7:0] POS_START2 = 8'd11;
    localparam logic [7:0] POS_CTRL   = 8'd12;
    localparam logic [7:0] POS_ID0    = 8'd14;
    localparam logic [7:0] POS_ID3    = 8'd17;
    localparam logic [7:0] POS_DATA0  = 8'd18;
    localparam logic [7:0] POS_DATA3  = 8'd21;
    localparam logic [7:0] POS_SAT    = 8'd255;

    logic [7:0]  r_pos, n_pos;
    t_status     r_herr, n_herr;
    logic [47:0] r_addr, n_addr;
    logic [31:0] r_ident, n_ident;
    logic [31:0] r_data, n_data;
    logic        r_frm_valid;
    t_frame      r_frm;

    logic        in_acc;
    logic [7:0]  addr_off;
    logic [7:0]  id_off;
    logic [7:0]  data_off;
    logic [7:0]  id_byte;

    // Hold the input only when a finished frame cannot move on.
    assign o_in_stall = r_frm_valid && !i_frm_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign addr_off = r_pos - POS_ADDR0;
    assign id_off   = r_pos - POS_ID0;
    assign data_off = r_pos - POS_DATA0;
    assign id_byte  = i_rx_byte - BYTE_OFFSET;

    // Frame state including the byte now arriving.
    always_comb begin
        n_pos   = (r_pos == POS_SAT) ? r_pos : r_pos + 8'd1;
        n_herr  = r_herr;
        n_addr  = r_addr;
        n_ident = r_ident;
        n_data  = r_data;
        if (r_herr == ST_OK) begin
            if ((r_pos == POS_START1 || r_pos == POS_START2) && i_rx_byte != START_MARK) begin
                n_herr = ST_BAD_DELIM;
            end else if (r_pos == POS_CTRL && i_rx_byte != CONTROL_REPLY) begin
                n_herr = ST_WRONG_CTRL;
            end
        end
        if (r_pos >= POS_ADDR0 && r_pos <= POS_ADDR5) begin
            n_addr[{addr_off[2:0], 3'b000} +: 8] = i_rx_byte;
        end
        if (r_pos >= POS_ID0 && r_pos <= POS_ID3) begin
            n_ident[{id_off[1:0], 3'b000} +: 8] = id_byte;
        end
        if (r_pos >= POS_DATA0 && r_pos <= POS_DATA3) begin
            n_data[{data_off[1:0], 3'b000} +: 8] = i_rx_byte;
        end
    end

    // Per-frame state; the final byte clears it for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_herr  <= ST_OK;
            r_addr  <= '0;
            r_ident <= '0;
            r_data  <= '0;
        end else if (in_acc) begin
            if (i_last_byte) begin
                r_pos   <= '0;
                r_herr  <= ST_OK;
                r_addr  <= '0;
                r_ident <= '0;
                r_data  <= '0;
            end else begin
                r_pos   <= n_pos;
                r_herr  <= n_herr;
                r_addr  <= n_addr;
                r_ident <= n_ident;
                r_data  <= n_data;
            end
        end
    end

    // Frame record valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_frm_valid <= 1'b1;
        end else if (i_frm_ready) begin
            r_frm_valid <= 1'b0;
        end
    end

    // Frame record payload.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_frm.pos    <= r_pos;
            r_frm.end_ok <= (i_rx_byte == END_MARK);
            r_frm.herr   <= n_herr;
            r_frm.addr   <= n_addr;
            r_frm.ident  <= n_ident;
            r_frm.data   <= n_data;
        end
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

endmodule

FILE: rtl/mrfp_decode.sv
// ----------------------------------------------------------------------------
// Meter reply frame parser decode stage
// Resolves the frame status, matches the identifier against the configured
// identifiers and converts the data bytes to a decimal reading.
// ----------------------------------------------------------------------------
module mrfp_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frm_valid,
    output logic             o_frm_ready,
    input  mrfp_pkg::t_frame i_frm,
    input  logic [31:0]      i_energy_id,
    input  logic [31:0]      i_voltage_id,
    input  logic [31:0]      i_current_id,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [47:0]      o_meter_address,
    output logic [31:0]      o_data_identifier,
    output logic [26:0]      o_reading_value
);
    import mrfp_pkg::*;

    // Final byte offsets below which a section is missing.
    localparam logic [7:0] POS_MIN_DELIM = 8'd4;
    localparam logic [7:0] POS_MIN_CTRL  = 8'd12;
    localparam logic [7:0] POS_MIN_ID    = 8'd17;
    localparam logic [7:0] POS_DATA0     = 8'd18;

    localparam logic [2:0] CNT_ENERGY  = 3'd4;
    localparam logic [2:0] CNT_VOLTAGE = 3'd2;
    localparam logic [2:0] CNT_CURRENT = 3'd3;
    localparam logic [2:0] CNT_NONE    = 3'd0;

    logic        r_out_valid;
    t_status     r_status;
    logic [47:0] r_addr;
    logic [31:0] r_ident;
    logic [26:0] r_value;

    logic        out_adv;
    logic [2:0]  count;
    logic        is_energy;
    logic        is_current;
    t_status     status;
    logic [7:0]  d0, d1, d2, d3;
    logic [7:0]  p0, p1, p2, p3;
    logic [26:0] term1, term2, term3, value;

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign o_frm_ready = out_adv;

    // Identifier match, energy first.
    always_comb begin
        is_energy  = 1'b0;
        is_current = 1'b0;
        if (i_frm.ident == i_energy_id) begin
            count     = CNT_ENERGY;
            is_energy = 1'b1;
        end else if (i_frm.ident == i_voltage_id) begin
            count = CNT_VOLTAGE;
        end else if (i_frm.ident == i_current_id) begin
            count      = CNT_CURRENT;
            is_current = 1'b1;
        end else begin
            count = CNT_NONE;
        end
    end

    // Status in priority order.
    always_comb begin
        if (i_frm.pos < POS_MIN_DELIM) begin
            status = ST_TOO_SHORT;
        end else if (i_frm.herr == ST_BAD_DELIM || !i_frm.end_ok) begin
            status = ST_BAD_DELIM;
        end else if (i_frm.pos < POS_MIN_CTRL) begin
            status = ST_TOO_SHORT;
        end else if (i_frm.herr == ST_WRONG_CTRL) begin
            status = ST_WRONG_CTRL;
        end else if (i_frm.pos < POS_MIN_ID) begin
            status = ST_TOO_SHORT;
        end else if (count == CNT_NONE) begin
            status = ST_UNKNOWN_ID;
        end else if (i_frm.pos < POS_DATA0 + {5'd0, count}) begin
            status = ST_TOO_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    // Unscramble the data bytes and mask the sign bit of the top byte of energy and current readings.
    assign d0 = i_frm.data[7:0] - BYTE_OFFSET;
    assign d1 = i_frm.data[15:8] - BYTE_OFFSET;
    assign d2 = (i_frm.data[23:16] - BYTE_OFFSET) & (is_current ? SIGN_MASK : 8'hff);
    assign d3 = (i_frm.data[31:24] - BYTE_OFFSET) & SIGN_MASK;

    assign p0 = bcd_pair(d0);
    assign p1 = bcd_pair(d1);
    assign p2 = (is_energy || is_current) ? bcd_pair(d2) : 8'd0;
    assign p3 = is_energy ? bcd_pair(d3) : 8'd0;

    // Weighted sum of the digit pairs.
    assign term1 = {19'd0, p1} * 27'd100;
    assign term2 = {19'd0, p2} * 27'd10000;
    assign term3 = {19'd0, p3} * 27'd1000000;
    assign value = {19'd0, p0} + term1 + term2 + term3;

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= i_frm_valid;
        end
    end

    // Result register payload; error results carry zero fields.
    always_ff @(posedge i_clk) begin
        if (out_adv && i_frm_valid) begin
            r_status <= status;
            if (status == ST_OK) begin
                r_addr  <= i_frm.addr;
                r_ident <= i_frm.ident;
                r_value <= value;
            end else begin
                r_addr  <= '0;
                r_ident <= '0;
                r_value <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_meter_address   = r_addr;
    assign o_data_identifier = r_ident;
    assign o_reading_value   = r_value;

endmodule

FILE: rtl/meter_reply_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Meter reply frame parser
// Parses a meter read reply one byte per cycle unless stalled, giving one result
// transaction per frame with status, address, identifier and reading.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on the input channel (i_in_valid, o_in_stall,
// i_rx_byte, i_last_byte), preamble first, one byte per cycle at full rate
// while o_in_stall is low. The transaction with i_last_byte set ends the
// frame and produces exactly one result transaction on the output channel
// (o_out_valid, i_out_stall); all other bytes produce nothing. A frame result
// passes through the frame record register and then the result register
// after its final byte is taken. Throughput is one byte per cycle while
// o_in_stall is low.
// When the receiver stalls, the result register holds; the frame record
// absorbs one more finished frame, and o_in_stall rises only while both are
// full. Identifier registers are written on the configuration channel,
// which is always ready, only by the user while idle; the block does not check.
// Reset (i_rst_n low, synchronous) clears the frame state and both valid
// flags and restores the default identifiers.
// ----------------------------------------------------------------------------
`include "meter_reply_frame_parser_unit_assert.svh"

module meter_reply_frame_parser_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [47:0]                    o_meter_address,
    output logic [31:0]                    o_data_identifier,
    output logic [26:0]                    o_reading_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import mrfp_pkg::*;

    logic [31:0] r_energy_id;
    logic [31:0] r_voltage_id;
    logic [31:0] r_current_id;

    logic        frm_valid;
    logic        frm_ready;
    t_frame      frm;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Identifier registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_id  <= ENERGY_ID_RST;
            r_voltage_id <= VOLTAGE_ID_RST;
            r_current_id <= CURRENT_ID_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENERGY:  r_energy_id  <= i_cfg_data;
                CFG_VOLTAGE: r_voltage_id <= i_cfg_data;
                CFG_CURRENT: r_current_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte capture and frame record.
    mrfp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .o_frm_valid (frm_valid),
        .i_frm_ready (frm_ready),
        .o_frm       (frm)
    );

    // Status, identifier match and reading conversion.
    mrfp_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frm_valid       (frm_valid),
        .o_frm_ready       (frm_ready),
        .i_frm             (frm),
        .i_energy_id       (r_energy_id),
        .i_voltage_id      (r_voltage_id),
        .i_current_id      (r_current_id),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_meter_address   (o_meter_address),
        .o_data_identifier (o_data_identifier),
        .o_reading_value   (o_reading_value)
    );

    // Input stalls only when the record and the result register are both full.
    `MRFP_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, frm_valid && o_out_valid && i_out_stall)
    // Error results carry zero fields.
    `MRFP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_meter_address == '0 && o_data_identifier == '0 && o_reading_value == '0)
    // A good reading never exceeds the largest decodable value.
    `MRFP_ASSERT_IMP(a_value_range, i_clk, i_rst_n, o_out_valid && o_status == ST_OK, o_reading_value <= READING_MAX)
    // A taken final byte always leaves a frame record behind.
    `MRFP_ASSERT_NXT(a_last_loads, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_last_byte, frm_valid)

endmodule
